// File: design/tbb_pkg.sv
// shared widths and types for the track bounding box / charge statistics block
// no dependencies
package tbb_pkg;

  localparam int COORD_BITS  = 16;
  localparam int CHARGE_BITS = 16;
  localparam int SUM_BITS    = 28;
  localparam int FRAC_BITS   = 16;
  localparam int DENS_BITS   = SUM_BITS + FRAC_BITS;
  localparam int AREA_BITS   = 2 * COORD_BITS;
  localparam int VOL_BITS    = 3 * COORD_BITS;
  localparam int DIV_CNT_BITS = $clog2(DENS_BITS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [CHARGE_BITS-1:0]       charge_t;
  typedef logic [SUM_BITS-1:0]          csum_t;

  // one finished track, as handed from front to back
  typedef struct packed {
    coord_t  x_min;
    coord_t  x_max;
    coord_t  y_min;
    coord_t  y_max;
    coord_t  z_min;
    coord_t  z_max;
    csum_t   charge_sum;
    charge_t charge_peak;
  } track_rec_t;

  // queue status seen by its two neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// File: design/tbb_front.sv
// front part: per-point extremes and charge accumulation, emits a track record
// depends on tbb_pkg
module tbb_front import tbb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  coord_t     x_coord_i,
  input  coord_t     y_coord_i,
  input  coord_t     z_coord_i,
  input  charge_t    charge_i,
  input  logic       last_point_i,
  output logic       rec_push_o,
  output track_rec_t rec_o
);

  logic    first_q, first_d;
  coord_t  x_lo_q, x_hi_q, y_lo_q, y_hi_q, z_lo_q, z_hi_q;
  coord_t  x_lo_n, x_hi_n, y_lo_n, y_hi_n, z_lo_n, z_hi_n;
  coord_t  x_lo_d, x_hi_d, y_lo_d, y_hi_d, z_lo_d, z_hi_d;
  csum_t   sum_q, sum_d, sum_n;
  charge_t peak_q, peak_d, peak_n;
  logic [SUM_BITS:0] sum_wide;

  always_comb begin
    if (first_q) begin
      x_lo_n = x_coord_i;  x_hi_n = x_coord_i;
      y_lo_n = y_coord_i;  y_hi_n = y_coord_i;
      z_lo_n = z_coord_i;  z_hi_n = z_coord_i;
    end else begin
      x_lo_n = (x_coord_i < x_lo_q) ? x_coord_i : x_lo_q;
      x_hi_n = (x_coord_i > x_hi_q) ? x_coord_i : x_hi_q;
      y_lo_n = (y_coord_i < y_lo_q) ? y_coord_i : y_lo_q;
      y_hi_n = (y_coord_i > y_hi_q) ? y_coord_i : y_hi_q;
      z_lo_n = (z_coord_i < z_lo_q) ? z_coord_i : z_lo_q;
      z_hi_n = (z_coord_i > z_hi_q) ? z_coord_i : z_hi_q;
    end
    // saturating charge total
    sum_wide = {1'b0, sum_q} + {{(SUM_BITS + 1 - CHARGE_BITS){1'b0}}, charge_i};
    sum_n    = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];
    peak_n   = (charge_i > peak_q) ? charge_i : peak_q;

    rec_o.x_min       = x_lo_n;
    rec_o.x_max       = x_hi_n;
    rec_o.y_min       = y_lo_n;
    rec_o.y_max       = y_hi_n;
    rec_o.z_min       = z_lo_n;
    rec_o.z_max       = z_hi_n;
    rec_o.charge_sum  = sum_n;
    rec_o.charge_peak = peak_n;
    rec_push_o        = accept_i & last_point_i;

    first_d = first_q;
    x_lo_d = x_lo_q;  x_hi_d = x_hi_q;
    y_lo_d = y_lo_q;  y_hi_d = y_hi_q;
    z_lo_d = z_lo_q;  z_hi_d = z_hi_q;
    sum_d  = sum_q;
    peak_d = peak_q;
    if (accept_i) begin
      if (last_point_i) begin
        // track closed: clear for the next one
        first_d = 1'b1;
        x_lo_d = '0;  x_hi_d = '0;
        y_lo_d = '0;  y_hi_d = '0;
        z_lo_d = '0;  z_hi_d = '0;
        sum_d  = '0;
        peak_d = '0;
      end else begin
        first_d = 1'b0;
        x_lo_d = x_lo_n;  x_hi_d = x_hi_n;
        y_lo_d = y_lo_n;  y_hi_d = y_hi_n;
        z_lo_d = z_lo_n;  z_hi_d = z_hi_n;
        sum_d  = sum_n;
        peak_d = peak_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      x_lo_q <= '0;  x_hi_q <= '0;
      y_lo_q <= '0;  y_hi_q <= '0;
      z_lo_q <= '0;  z_hi_q <= '0;
      sum_q  <= '0;
      peak_q <= '0;
    end else begin
      first_q <= first_d;
      x_lo_q <= x_lo_d;  x_hi_q <= x_hi_d;
      y_lo_q <= y_lo_d;  y_hi_q <= y_hi_d;
      z_lo_q <= z_lo_d;  z_hi_q <= z_hi_d;
      sum_q  <= sum_d;
      peak_q <= peak_d;
    end
  end

endmodule

// File: design/tbb_queue.sv
// short queue of finished track records between front and back
// depends on tbb_pkg
module tbb_queue import tbb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  track_rec_t  rec_i,
  input  logic        pop_i,
  output track_rec_t  rec_o,
  output queue_stat_t stat_o
);

  track_rec_t slot_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wptr_q, rptr_q;
  logic [QPTR_BITS:0]   cnt_q;
  logic do_push, do_pop;

  assign stat_o.full  = (cnt_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign rec_o        = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: design/tbb_back.sv
// back part: box volume by two multiplies, bit-serial density division,
// and the result register; depends on tbb_pkg
module tbb_back import tbb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  queue_stat_t q_stat_i,
  input  track_rec_t  q_rec_i,
  output logic        q_pop_o,
  input  logic        res_pop_i,
  output logic        res_valid_o,
  output track_rec_t  res_rec_o,
  output logic [DENS_BITS-1:0] res_density_o,
  output logic        res_density_valid_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_AREA,
    S_VOLUME,
    S_DIVIDE,
    S_DONE
  } back_state_e;

  back_state_e state_q;
  track_rec_t  rec_q;
  logic [COORD_BITS-1:0]   dx_q, dy_q, dz_q;
  logic [AREA_BITS-1:0]    area_q;
  logic [VOL_BITS-1:0]     vol_q, rem_q;
  logic [DENS_BITS-1:0]    quo_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic                    res_valid_q;

  logic [COORD_BITS:0] dx_w, dy_w, dz_w;
  logic [VOL_BITS:0]   rem_sh, rem_sub;
  logic                fits, slot_free;

  // extents are never negative, so the low bits hold the unsigned width
  assign dx_w = {q_rec_i.x_max[COORD_BITS-1], q_rec_i.x_max}
              - {q_rec_i.x_min[COORD_BITS-1], q_rec_i.x_min};
  assign dy_w = {q_rec_i.y_max[COORD_BITS-1], q_rec_i.y_max}
              - {q_rec_i.y_min[COORD_BITS-1], q_rec_i.y_min};
  assign dz_w = {q_rec_i.z_max[COORD_BITS-1], q_rec_i.z_max}
              - {q_rec_i.z_min[COORD_BITS-1], q_rec_i.z_min};

  // one restoring division step
  assign rem_sh  = {rem_q, quo_q[DENS_BITS-1]};
  assign fits    = (rem_sh >= {1'b0, vol_q});
  assign rem_sub = rem_sh - {1'b0, vol_q};

  assign slot_free   = ~res_valid_q | res_pop_i;
  assign q_pop_o     = (state_q == S_IDLE) & ~q_stat_i.empty;
  assign res_valid_o = res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q             <= S_IDLE;
      res_valid_q         <= 1'b0;
      rec_q               <= '0;
      dx_q                <= '0;
      dy_q                <= '0;
      dz_q                <= '0;
      area_q              <= '0;
      vol_q               <= '0;
      rem_q               <= '0;
      quo_q               <= '0;
      cnt_q               <= '0;
      res_rec_o           <= '0;
      res_density_o       <= '0;
      res_density_valid_o <= 1'b0;
    end else begin
      // result register: loaded from the done state, freed by a pop
      if ((state_q == S_DONE) && slot_free) begin
        res_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!q_stat_i.empty) begin
            rec_q   <= q_rec_i;
            dx_q    <= dx_w[COORD_BITS-1:0];
            dy_q    <= dy_w[COORD_BITS-1:0];
            dz_q    <= dz_w[COORD_BITS-1:0];
            state_q <= S_AREA;
          end
        end
        S_AREA: begin
          area_q  <= dx_q * dy_q;
          state_q <= S_VOLUME;
        end
        S_VOLUME: begin
          vol_q   <= area_q * dz_q;
          rem_q   <= '0;
          quo_q   <= {rec_q.charge_sum, {FRAC_BITS{1'b0}}};
          cnt_q   <= DIV_CNT_BITS'(DENS_BITS - 1);
          state_q <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (vol_q == '0) begin
            // flat box: no density
            quo_q   <= '0;
            state_q <= S_DONE;
          end else begin
            rem_q <= fits ? rem_sub[VOL_BITS-1:0] : rem_sh[VOL_BITS-1:0];
            quo_q <= {quo_q[DENS_BITS-2:0], fits};
            cnt_q <= cnt_q - 1'b1;
            if (cnt_q == '0) state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            res_rec_o           <= rec_q;
            res_density_o       <= quo_q;
            res_density_valid_o <= (vol_q != '0);
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/track_bounding_box_charge_stats_core.sv
// track bounding box and charge statistics: one point per cycle, one result per track
// path: after its last point is taken, a track passes the queue hop, the area and volume
//   multiplies, 44 one-bit division steps and the result register; a flat box skips division
// throughput: points are taken every cycle while the queue is not full; the back part takes
//   a new track only when idle, so records wait in the 2-entry record queue
// reset: rst_ni is asynchronous active low, clears accumulators, queue and result
// depends on tbb_pkg, tbb_front, tbb_queue, tbb_back
module track_bounding_box_charge_stats_core import tbb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // point input, queue style
  input  logic                 push,
  output logic                 full,
  input  coord_t               x_coord_i,
  input  coord_t               y_coord_i,
  input  coord_t               z_coord_i,
  input  charge_t              charge_i,
  input  logic                 last_point_i,
  // track result, queue style
  output logic                 empty,
  input  logic                 pop,
  output coord_t               x_min_o,
  output coord_t               x_max_o,
  output coord_t               y_min_o,
  output coord_t               y_max_o,
  output coord_t               z_min_o,
  output coord_t               z_max_o,
  output csum_t                charge_sum_o,
  output charge_t              charge_peak_o,
  output logic [DENS_BITS-1:0] density_o,
  output logic                 density_valid_o
);

  logic        accept;
  logic        rec_push;
  track_rec_t  front_rec;
  track_rec_t  q_rec;
  queue_stat_t q_stat;
  logic        q_pop;
  logic        res_valid;
  track_rec_t  res_rec;

  // the queue must be able to take a record whenever a last point comes in,
  // so points are held off while it is full
  assign full   = q_stat.full;
  assign accept = push & ~q_stat.full;

  // front: extremes, saturating charge total and peak per point
  tbb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .x_coord_i    (x_coord_i),
    .y_coord_i    (y_coord_i),
    .z_coord_i    (z_coord_i),
    .charge_i     (charge_i),
    .last_point_i (last_point_i),
    .rec_push_o   (rec_push),
    .rec_o        (front_rec)
  );

  // finished tracks wait here while the back part divides
  tbb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rec_push),
    .rec_i  (front_rec),
    .pop_i  (q_pop),
    .rec_o  (q_rec),
    .stat_o (q_stat)
  );

  // back: volume, density division, result register
  tbb_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_stat_i            (q_stat),
    .q_rec_i             (q_rec),
    .q_pop_o             (q_pop),
    .res_pop_i           (pop),
    .res_valid_o         (res_valid),
    .res_rec_o           (res_rec),
    .res_density_o       (density_o),
    .res_density_valid_o (density_valid_o)
  );

  assign empty         = ~res_valid;
  assign x_min_o       = res_rec.x_min;
  assign x_max_o       = res_rec.x_max;
  assign y_min_o       = res_rec.y_min;
  assign y_max_o       = res_rec.y_max;
  assign z_min_o       = res_rec.z_min;
  assign z_max_o       = res_rec.z_max;
  assign charge_sum_o  = res_rec.charge_sum;
  assign charge_peak_o = res_rec.charge_peak;

endmodule
